### hdl/systematic_resampler_assert.svh
// Assertion macros for the systematic resampler.
// Included by the RTL files that carry concurrent checks; needs nothing else.
`ifndef SYSTEMATIC_RESAMPLER_ASSERT_SVH
`define SYSTEMATIC_RESAMPLER_ASSERT_SVH

// Same-cycle implication, disabled while reset is asserted.
`define SR_ASSERT_NOW(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("systematic_resampler check failed");

// Next-cycle implication, disabled while reset is asserted.
`define SR_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("systematic_resampler check failed");

`endif

### hdl/sr_pkg.sv
// Shared constants for the systematic resampler.
// No dependencies; imported by systematic_resampler.
`default_nettype none

package sr_pkg;

  localparam int unsigned IN_WEIGHT_W = 16;  // width of the weight port
  localparam int unsigned OFFSET_W    = 16;  // Q0.16 offset fraction
  localparam int unsigned INDEX_W     = 6;   // width of the selected index port

  // Codes carried by the action field.
  localparam logic ACT_LOAD  = 1'b0;
  localparam logic ACT_START = 1'b1;

endpackage

`default_nettype wire

### hdl/systematic_resampler.sv
// Systematic (low-variance) resampler: a load word stores one particle weight
// (a load into a full store is dropped and flags overflow on the run), and a
// start word with a random offset walks the stored weights and emits one
// selected particle index for every loaded particle. Load words are accepted
// whenever the block is idle. A start first sets up the run; then each index
// is emitted from the compare state, and each step of the walk index is a read
// of the weight memory, then an accumulate of weight times count. A stalled
// output holds the run. The input is not ready during a run. The comparison
// (m + offset)/N > cum/total is done by cross multiplication, never by division;
// the walk stops at the last loaded particle. The weight memory needs no clearing after reset.
// Depends on sr_pkg and systematic_resampler_assert.svh.
`default_nettype none

module systematic_resampler #(
  parameter int unsigned MAX_PARTICLES = 64,
  parameter int unsigned WEIGHT_BITS   = 16
) (
  input  wire logic                         clk,
  input  wire logic                         rst_n,
  input  wire logic                         in_valid,
  output logic                              in_ready,
  input  wire logic                         in_action,
  input  wire logic [sr_pkg::IN_WEIGHT_W-1:0] in_weight,
  input  wire logic [sr_pkg::OFFSET_W-1:0]  in_offset,
  output logic                              out_valid,
  input  wire logic                         out_ready,
  output logic [sr_pkg::INDEX_W-1:0]        out_selected_index,
  output logic                              out_last,
  output logic                              out_overflow
);

  import sr_pkg::*;

  localparam int unsigned CNT_W = $clog2(MAX_PARTICLES + 1);
  localparam int unsigned IDX_W = $clog2(MAX_PARTICLES);
  localparam int unsigned WB    = (WEIGHT_BITS < IN_WEIGHT_W) ? WEIGHT_BITS : IN_WEIGHT_W;
  localparam int unsigned SUM_W = WB + CNT_W;
  localparam int unsigned CN_W  = SUM_W + CNT_W;
  localparam int unsigned P_W   = WB + CNT_W;
  localparam int unsigned L_W   = CN_W + OFFSET_W;

  typedef enum logic [1:0] {S_IDLE, S_ADD, S_CMP} state_t;

  state_t             state_r;
  logic [CNT_W-1:0]   count_r;
  logic [SUM_W-1:0]   total_r;
  logic               dropped_r;
  logic [CNT_W-1:0]   n_r;
  logic [IDX_W-1:0]   idx_r;
  logic [IDX_W-1:0]   slot_r;
  logic [CN_W-1:0]    cn_r;
  logic [L_W-1:0]     lhs_r;
  logic               out_valid_r;
  logic [INDEX_W-1:0] out_index_r;
  logic               out_last_r;
  logic               out_overflow_r;

  logic [WB-1:0]      mem [MAX_PARTICLES];
  logic [WB-1:0]      rd_data_r;
  logic               rd_en;
  logic [IDX_W-1:0]   rd_addr;
  logic               wr_en;

  logic               in_acc;
  logic               full;
  logic               out_free;
  logic               emit;
  logic [P_W-1:0]     wprod;
  logic [CN_W-1:0]    cn_nxt;
  logic [L_W-1:0]     lhs_init;
  logic               above;
  logic               can_step;
  logic               slot_last;

  assign in_ready  = (state_r == S_IDLE);
  assign in_acc    = in_valid && in_ready;
  assign full      = (count_r == CNT_W'(MAX_PARTICLES));
  assign out_free  = !out_valid_r || out_ready;

  // Each step of the walk adds weight * N, so in the compare state cn_r holds cum * N.
  assign wprod     = P_W'(rd_data_r) * P_W'(n_r);
  assign cn_nxt    = cn_r + CN_W'(wprod);
  assign lhs_init  = L_W'(in_offset) * L_W'(total_r);
  assign above     = lhs_r > {cn_r, {OFFSET_W{1'b0}}};
  assign can_step  = (CNT_W'(idx_r) + CNT_W'(1)) < n_r;
  assign slot_last = (CNT_W'(slot_r) + CNT_W'(1)) == n_r;
  assign emit      = (state_r == S_CMP) && !(above && can_step) && out_free;

  assign wr_en   = in_acc && (in_action == ACT_LOAD) && !full;
  assign rd_en   = (in_acc && (in_action == ACT_START)) ||
                   ((state_r == S_CMP) && above && can_step);
  assign rd_addr = (state_r == S_IDLE) ? '0 : idx_r + IDX_W'(1);

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[count_r[IDX_W-1:0]] <= in_weight[WB-1:0];
    end
    if (rd_en) begin
      rd_data_r <= mem[rd_addr];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      count_r     <= '0;
      total_r     <= '0;
      dropped_r   <= 1'b0;
      idx_r       <= '0;
      slot_r      <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (emit) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
      case (state_r)
        S_IDLE: begin
          if (in_acc && (in_action == ACT_LOAD)) begin
            if (full) begin
              dropped_r <= 1'b1;
            end else begin
              count_r <= count_r + CNT_W'(1);
              total_r <= total_r + SUM_W'(in_weight[WB-1:0]);
            end
          end else if (in_acc) begin
            if (count_r == '0) begin
              dropped_r <= 1'b0;
              total_r   <= '0;
            end else begin
              n_r     <= count_r;
              idx_r   <= '0;
              slot_r  <= '0;
              cn_r    <= '0;
              lhs_r   <= lhs_init;
              state_r <= S_ADD;
            end
          end
        end
        S_ADD: begin
          cn_r    <= cn_nxt;
          state_r <= S_CMP;
        end
        S_CMP: begin
          if (above && can_step) begin
            idx_r   <= idx_r + IDX_W'(1);
            state_r <= S_ADD;
          end else if (out_free) begin
            out_index_r    <= INDEX_W'(idx_r);
            out_last_r     <= slot_last;
            out_overflow_r <= dropped_r;
            slot_r         <= slot_r + IDX_W'(1);
            lhs_r          <= lhs_r + (L_W'(total_r) << OFFSET_W);
            if (slot_last) begin
              count_r   <= '0;
              total_r   <= '0;
              dropped_r <= 1'b0;
              idx_r     <= '0;
              state_r   <= S_IDLE;
            end
          end
        end
        default: begin
          state_r <= S_IDLE;
        end
      endcase
    end
  end

  assign out_valid          = out_valid_r;
  assign out_selected_index = out_index_r;
  assign out_last           = out_last_r;
  assign out_overflow       = out_overflow_r;

`include "systematic_resampler_assert.svh"

  // The walk never leaves the loaded set.
  `SR_ASSERT_NOW(a_idx_in_range, clk, rst_n, state_r != S_IDLE, CNT_W'(idx_r) < n_r)
  // A load into a full store marks the run as overflowed.
  `SR_ASSERT_NEXT(a_drop_flag, clk, rst_n, in_acc && (in_action == ACT_LOAD) && full, dropped_r)
  // The walk index only moves forward within a run.
  `SR_ASSERT_NEXT(a_walk_fwd, clk, rst_n, state_r == S_CMP && above && can_step,
                  idx_r == $past(idx_r) + IDX_W'(1))
  // A start with particles loaded always begins a run.
  `SR_ASSERT_NEXT(a_start_run, clk, rst_n, in_acc && (in_action == ACT_START) && (count_r != '0),
                  state_r == S_ADD)

endmodule

`default_nettype wire

### tb/systematic_resampler_tb.sv
`timescale 1ns / 100ps
// Self-checking testbench for systematic_resampler: directed table words, then
// random particle sets; results checked vs a cycle-free predictor or typed row.
// Depends on sr_pkg and the systematic_resampler RTL.

module systematic_resampler_tb;
  import sr_pkg::*;

  localparam int unsigned MAX_PARTS   = 64;
  localparam int unsigned STALL_LIMIT = 4000;
  localparam int unsigned RAND_WORDS  = 250;
  localparam int unsigned DRAIN_CYCLES = 250;
  localparam int          NUM_ROWS    = 22;

  typedef struct packed {
    logic [INDEX_W-1:0] idx;
    logic               last;
    logic               ovf;
  } pick_t;

  // One directed row: a word, how often it repeats, and an optional typed-in
  // expectation that every result of a start selects t_idx.
  typedef struct packed {
    logic                   act;
    logic [IN_WEIGHT_W-1:0] w;
    logic [OFFSET_W-1:0]    off;
    logic [7:0]             reps;
    logic                   typed;
    logic [INDEX_W-1:0]     t_idx;
    logic                   t_ovf;
  } stim_row_t;

  logic                   clk;
  logic                   rst_n = 1'b0;
  logic                   in_valid = 1'b0;
  logic                   in_ready;
  logic                   in_action = ACT_LOAD;
  logic [IN_WEIGHT_W-1:0] in_weight = '0;
  logic [OFFSET_W-1:0]    in_offset = '0;
  logic                   out_valid;
  logic                   out_ready = 1'b0;
  logic [INDEX_W-1:0]     out_selected_index;
  logic                   out_last;
  logic                   out_overflow;

  // Predictor state.
  logic [IN_WEIGHT_W-1:0] wt_mem [MAX_PARTS];
  int unsigned            n_loaded = 0;
  longint unsigned        wt_total = 0;
  bit                     dropped = 1'b0;

  pick_t       picks_due [$];
  pick_t       fresh [$];
  int unsigned mismatches = 0;
  int unsigned quiet_cycles = 0;
  bit          calm = 1'b0;
  bit          stim_done = 1'b0;
  stim_row_t   script [NUM_ROWS];

  systematic_resampler #(
    .MAX_PARTICLES(MAX_PARTS),
    .WEIGHT_BITS  (IN_WEIGHT_W)
  ) dut (
    .clk               (clk),
    .rst_n             (rst_n),
    .in_valid          (in_valid),
    .in_ready          (in_ready),
    .in_action         (in_action),
    .in_weight         (in_weight),
    .in_offset         (in_offset),
    .out_valid         (out_valid),
    .out_ready         (out_ready),
    .out_selected_index(out_selected_index),
    .out_last          (out_last),
    .out_overflow      (out_overflow)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  task automatic report_mismatch(input string msg);
    $display("%0t: %s", $time, msg);
    mismatches++;
  endtask

  // Applies one accepted word to the predictor; a start leaves its selected
  // indices in fresh and clears the particle set.
  task automatic resample_word(input logic act, input logic [IN_WEIGHT_W-1:0] w,
                               input logic [OFFSET_W-1:0] off);
    longint unsigned thresh;
    longint unsigned cum;
    int unsigned     walk;
    int unsigned     m;
    pick_t           p;
    if (act == ACT_LOAD) begin
      if (n_loaded < MAX_PARTS) begin
        wt_mem[n_loaded] = w;
        wt_total += 64'(w);
        n_loaded++;
      end else begin
        dropped = 1'b1;
      end
    end else begin
      walk = 0;
      cum = (n_loaded > 0) ? 64'(wt_mem[0]) : 64'd0;
      for (m = 0; m < n_loaded; m++) begin
        // (m + off/65536)/N > cum/total, cross-multiplied.
        thresh = (64'(m) * 64'd65536 + 64'(off)) * wt_total;
        while (walk + 1 < n_loaded && thresh > cum * 64'(n_loaded) * 64'd65536) begin
          walk++;
          cum += 64'(wt_mem[walk]);
        end
        p.idx  = walk[INDEX_W-1:0];
        p.last = (m + 1 == n_loaded);
        p.ovf  = dropped;
        fresh = {fresh, p};
      end
      n_loaded = 0;
      wt_total = 0;
      dropped  = 1'b0;
    end
  endtask

  task automatic send_word(input logic act, input logic [IN_WEIGHT_W-1:0] w,
                           input logic [OFFSET_W-1:0] off, input bit typed,
                           input logic [INDEX_W-1:0] t_idx, input logic t_ovf);
    int unsigned n_before;
    int unsigned k;
    pick_t       p;
    while (!calm && $urandom_range(0, 99) < 20) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid  <= 1'b1;
    in_action <= act;
    in_weight <= w;
    in_offset <= off;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    n_before = n_loaded;
    fresh.delete();
    resample_word(act, w, off);
    if (typed && act == ACT_START) begin
      // The expectation can be read straight off the row: one result per
      // loaded particle, all the same index, last on the final one.
      fresh.delete();
      for (k = 0; k < n_before; k++) begin
        p.idx  = t_idx;
        p.last = (k + 1 == n_before);
        p.ovf  = t_ovf;
        fresh = {fresh, p};
      end
    end
    picks_due = {picks_due, fresh};
    fresh.delete();
  endtask

  always @(posedge clk) begin
    out_ready <= calm || ($urandom_range(0, 99) >= 20);
  end

  always @(posedge clk) begin : result_check
    pick_t want;
    if (rst_n && out_valid && out_ready) begin
      if (picks_due.size() == 0) begin
        report_mismatch($sformatf("index %0d arrived with nothing outstanding",
                                  out_selected_index));
      end else begin
        want = picks_due.pop_front();
        if (out_selected_index !== want.idx)
          report_mismatch($sformatf("selected_index got %0d want %0d",
                                    out_selected_index, want.idx));
        if (out_last !== want.last)
          report_mismatch($sformatf("last got %0b want %0b", out_last, want.last));
        if (out_overflow !== want.ovf)
          report_mismatch($sformatf("overflow got %0b want %0b", out_overflow, want.ovf));
      end
    end
  end

  // Ends the run if nothing moves on either side for too long while work is due.
  always @(posedge clk) begin
    if (!rst_n || (in_valid && in_ready) || (out_valid && out_ready) ||
        (stim_done && picks_due.size() == 0)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= STALL_LIMIT) begin
      $display("FAILURE");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  initial begin
    int unsigned            items;
    int unsigned            n;
    int unsigned            pick;
    int unsigned            style;
    int                     r;
    logic [IN_WEIGHT_W-1:0] w;
    logic [OFFSET_W-1:0]    off;

    script = '{
      // Start with nothing loaded: no result at all.
      '{ACT_START, 16'h0000, 16'h1357, 8'd1,  1'b1, 6'd0, 1'b0},
      // A single particle always selects itself.
      '{ACT_LOAD,  16'hFFFF, 16'h0000, 8'd1,  1'b0, 6'd0, 1'b0},
      '{ACT_START, 16'h0000, 16'h0000, 8'd1,  1'b1, 6'd0, 1'b0},
      // Zero total weight selects index 0 in every slot.
      '{ACT_LOAD,  16'h0000, 16'hFFFF, 8'd3,  1'b0, 6'd0, 1'b0},
      '{ACT_START, 16'hFFFF, 16'hFFFF, 8'd1,  1'b1, 6'd0, 1'b0},
      '{ACT_LOAD,  16'hFFFF, 16'h0000, 8'd1,  1'b0, 6'd0, 1'b0},
      '{ACT_LOAD,  16'h0000, 16'hFFFF, 8'd1,  1'b0, 6'd0, 1'b0},
      '{ACT_LOAD,  16'h0001, 16'h0000, 8'd1,  1'b0, 6'd0, 1'b0},
      '{ACT_LOAD,  16'h8000, 16'h0000, 8'd1,  1'b0, 6'd0, 1'b0},
      '{ACT_START, 16'h0000, 16'h0000, 8'd1,  1'b0, 6'd0, 1'b0},
      '{ACT_LOAD,  16'h0001, 16'h0000, 8'd1,  1'b0, 6'd0, 1'b0},
      '{ACT_LOAD,  16'hFFFF, 16'h0000, 8'd1,  1'b0, 6'd0, 1'b0},
      '{ACT_START, 16'h0000, 16'hFFFF, 8'd1,  1'b0, 6'd0, 1'b0},
      // One load beyond capacity is dropped and flagged on the whole run.
      '{ACT_LOAD,  16'hAAAA, 16'h5555, 8'd65, 1'b0, 6'd0, 1'b0},
      '{ACT_START, 16'h5555, 16'h5555, 8'd1,  1'b0, 6'd0, 1'b0},
      // The start above cleared the flag and the set.
      '{ACT_START, 16'h0000, 16'h0000, 8'd1,  1'b1, 6'd0, 1'b0},
      // Exactly full, nothing dropped.
      '{ACT_LOAD,  16'h5555, 16'hAAAA, 8'd64, 1'b0, 6'd0, 1'b0},
      '{ACT_START, 16'h0000, 16'h0000, 8'd1,  1'b0, 6'd0, 1'b0},
      '{ACT_LOAD,  16'h00FF, 16'h0000, 8'd1,  1'b0, 6'd0, 1'b0},
      '{ACT_LOAD,  16'h0000, 16'h0000, 8'd1,  1'b0, 6'd0, 1'b0},
      '{ACT_LOAD,  16'hFF00, 16'h0000, 8'd1,  1'b0, 6'd0, 1'b0},
      '{ACT_START, 16'h0000, 16'h8000, 8'd1,  1'b0, 6'd0, 1'b0}
    };

    repeat (6) @(posedge clk);
    rst_n <= 1'b1;

    for (r = 0; r < NUM_ROWS; r++) begin
      repeat (script[r].reps)
        send_word(script[r].act, script[r].w, script[r].off, script[r].typed,
                  script[r].t_idx, script[r].t_ovf);
    end

    // Random particle sets, each closed by a start; a few bare starts as noise.
    items = 0;
    while (items < RAND_WORDS) begin
      calm = (items >= 100 && items < 200);
      if ($urandom_range(0, 99) < 5) begin
        send_word(ACT_START, IN_WEIGHT_W'($urandom), OFFSET_W'($urandom),
                  1'b0, '0, 1'b0);
        items++;
      end else begin
        pick = $urandom_range(0, 99);
        if (pick < 70)      n = $urandom_range(1, 8);
        else if (pick < 92) n = $urandom_range(9, 40);
        else if (pick < 97) n = $urandom_range(41, 64);
        else                n = $urandom_range(65, 70);
        style = $urandom_range(0, 3);
        repeat (n) begin
          case (style)
            0: w = IN_WEIGHT_W'($urandom);
            1: w = IN_WEIGHT_W'($urandom_range(0, 15));
            2: w = ($urandom_range(0, 2) == 0) ? IN_WEIGHT_W'($urandom) : 16'h0000;
            default: w = ($urandom_range(0, 7) == 0) ? 16'hFFFF :
                         IN_WEIGHT_W'($urandom_range(0, 3));
          endcase
          send_word(ACT_LOAD, w, OFFSET_W'($urandom), 1'b0, '0, 1'b0);
          items++;
        end
        pick = $urandom_range(0, 9);
        off = (pick == 0) ? 16'h0000 : (pick == 1) ? 16'hFFFF : OFFSET_W'($urandom);
        send_word(ACT_START, IN_WEIGHT_W'($urandom), off, 1'b0, '0, 1'b0);
        items++;
      end
    end
    calm = 1'b0;
    in_valid <= 1'b0;
    stim_done = 1'b1;

    while (picks_due.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    if (mismatches == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule
